[rtl/core/brcw_pkg.sv]
// shared types, constants and register indexes of the box region address walker
package brcw_pkg;

  localparam int DIMS_DEF         = 3;
  localparam int EXTENT_BITS_DEF  = 12;
  localparam int INDEX_BITS_DEF   = 32;
  localparam int LAYER_COUNT_BITS = 9;
  localparam int LAYER_POS_BITS   = 8;
  localparam int CFG_INDEX_BITS   = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_EXTENTS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_EXTENTS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_EXTENTS   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LAYER_COUNT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_FIRST   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_FIRST     = 3'd5;

  localparam logic [LAYER_COUNT_BITS-1:0] LAYER_COUNT_RESET = 9'd1;

  typedef enum logic [1:0] {
    ST_PITCH_A,
    ST_PITCH_B,
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic pitch_a;
    logic pitch_b;
    logic step;
    logic emit;
  } cmd_t;

endpackage

[rtl/core/brcw_stream_if.sv]
// handshake channel interfaces for the request and result words
interface brcw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface brcw_out_if #(
  parameter int INDEX_BITS = brcw_pkg::INDEX_BITS_DEF
);
  logic                                    valid;
  logic                                    ready;
  logic [INDEX_BITS-1:0]                   source_index;
  logic [INDEX_BITS-1:0]                   dest_index;
  logic [brcw_pkg::LAYER_POS_BITS-1:0]     layer_index;
  logic                                    run_end;
  logic                                    last;

  modport source (output valid, output source_index, output dest_index, output layer_index,
                  output run_end, output last, input ready);
  modport sink (input valid, input source_index, input dest_index, input layer_index,
                input run_end, input last, output ready);
endinterface

[rtl/core/brcw_cfg_regs.sv]
// configuration register file of the address walker
module brcw_cfg_regs #(
  parameter int EXTENT_BITS = brcw_pkg::EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = brcw_pkg::INDEX_BITS_DEF,
  parameter int CFG_W       = 3 * EXTENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [brcw_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  output logic [3*EXTENT_BITS-1:0]               region_r,
  output logic [3*EXTENT_BITS-1:0]               src_ext_r,
  output logic [3*EXTENT_BITS-1:0]               dst_ext_r,
  output logic [brcw_pkg::LAYER_COUNT_BITS-1:0]  layers_r,
  output logic [INDEX_BITS-1:0]                  src_first_r,
  output logic [INDEX_BITS-1:0]                  dst_first_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r    <= '0;
      src_ext_r   <= '0;
      dst_ext_r   <= '0;
      layers_r    <= brcw_pkg::LAYER_COUNT_RESET;
      src_first_r <= '0;
      dst_first_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        brcw_pkg::CFG_REGION_EXTENTS: region_r    <= cfg_data[3*EXTENT_BITS-1:0];
        brcw_pkg::CFG_SOURCE_EXTENTS: src_ext_r   <= cfg_data[3*EXTENT_BITS-1:0];
        brcw_pkg::CFG_DEST_EXTENTS:   dst_ext_r   <= cfg_data[3*EXTENT_BITS-1:0];
        brcw_pkg::CFG_LAYER_COUNT:    layers_r    <= cfg_data[brcw_pkg::LAYER_COUNT_BITS-1:0];
        brcw_pkg::CFG_SOURCE_FIRST:   src_first_r <= cfg_data[INDEX_BITS-1:0];
        brcw_pkg::CFG_DEST_FIRST:     dst_first_r <= cfg_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/brcw_ctrl.sv]
// controller: pitch computation sequence and request/result handshake
module brcw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output brcw_pkg::cmd_t  cmd
);

  brcw_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign accept = in_valid && in_ready;

  // any register write invalidates the slab and layer pitches
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = brcw_pkg::ST_PITCH_A;
    end else begin
      case (state_r)
        brcw_pkg::ST_PITCH_A: state_nxt = brcw_pkg::ST_PITCH_B;
        brcw_pkg::ST_PITCH_B: state_nxt = brcw_pkg::ST_IDLE;
        brcw_pkg::ST_IDLE: begin
          if (accept) state_nxt = brcw_pkg::ST_EMIT;
        end
        brcw_pkg::ST_EMIT:    state_nxt = brcw_pkg::ST_IDLE;
        default:              state_nxt = brcw_pkg::ST_PITCH_A;
      endcase
    end
  end

  always_comb begin
    // a register write in the same cycle would drop the request word
    in_ready     = (state_r == brcw_pkg::ST_IDLE) && !cfg_we && (!out_valid_r || out_ready);
    cmd.pitch_a  = (state_r == brcw_pkg::ST_PITCH_A);
    cmd.pitch_b  = (state_r == brcw_pkg::ST_PITCH_B);
    cmd.step     = accept;
    cmd.emit     = (state_r == brcw_pkg::ST_EMIT);
    // the output word is always free by the emit cycle
    out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brcw_pkg::ST_PITCH_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/brcw_datapath.sv]
// datapath: pitch multipliers, walk position and base registers, output word
module brcw_datapath #(
  parameter int DIMS        = brcw_pkg::DIMS_DEF,
  parameter int EXTENT_BITS = brcw_pkg::EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = brcw_pkg::INDEX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  brcw_pkg::cmd_t                         cmd,
  input  logic                                   restart,
  input  logic [3*EXTENT_BITS-1:0]               region,
  input  logic [3*EXTENT_BITS-1:0]               src_ext,
  input  logic [3*EXTENT_BITS-1:0]               dst_ext,
  input  logic [brcw_pkg::LAYER_COUNT_BITS-1:0]  layers,
  input  logic [INDEX_BITS-1:0]                  src_first,
  input  logic [INDEX_BITS-1:0]                  dst_first,
  output logic [INDEX_BITS-1:0]                  source_index,
  output logic [INDEX_BITS-1:0]                  dest_index,
  output logic [brcw_pkg::LAYER_POS_BITS-1:0]    layer_index,
  output logic                                   run_end,
  output logic                                   last
);

  localparam int EB = EXTENT_BITS;
  localparam int WB = EXTENT_BITS + 1;
  localparam int PB = 2 * WB;
  localparam int LB = 3 * WB;
  localparam int LPB = brcw_pkg::LAYER_POS_BITS;
  localparam int LCB = brcw_pkg::LAYER_COUNT_BITS;

  // extents minus one; dimensions beyond DIMS count as extent one
  logic [EB-1:0] rx, ry, rz, sx, sy, sz, dx, dy, dz;
  assign rx = region[EB-1:0];
  assign ry = (DIMS > 1) ? region[2*EB-1:EB] : '0;
  assign rz = (DIMS > 2) ? region[3*EB-1:2*EB] : '0;
  assign sx = src_ext[EB-1:0];
  assign sy = (DIMS > 1) ? src_ext[2*EB-1:EB] : '0;
  assign sz = (DIMS > 2) ? src_ext[3*EB-1:2*EB] : '0;
  assign dx = dst_ext[EB-1:0];
  assign dy = (DIMS > 1) ? dst_ext[2*EB-1:EB] : '0;
  assign dz = (DIMS > 2) ? dst_ext[3*EB-1:2*EB] : '0;

  logic [WB-1:0] sw0, sw1, sw2, dw0, dw1, dw2;
  assign sw0 = WB'(sx) + WB'(1);
  assign sw1 = WB'(sy) + WB'(1);
  assign sw2 = WB'(sz) + WB'(1);
  assign dw0 = WB'(dx) + WB'(1);
  assign dw1 = WB'(dy) + WB'(1);
  assign dw2 = WB'(dz) + WB'(1);

  // layer count zero walks one layer, above 256 walks 256
  logic [LCB-1:0] lc_m1;
  logic [LPB-1:0] layers_m1;
  assign lc_m1 = layers - LCB'(1);
  always_comb begin
    if (layers == '0) begin
      layers_m1 = '0;
    end else if (lc_m1[LCB-1]) begin
      layers_m1 = '1;
    end else begin
      layers_m1 = lc_m1[LPB-1:0];
    end
  end

  // pitches, recomputed in two steps after every register write
  logic [PB-1:0]         s_slab_pitch_r, d_slab_pitch_r;
  logic [INDEX_BITS-1:0] s_layer_pitch_r, d_layer_pitch_r;

  always_ff @(posedge clk) begin
    if (cmd.pitch_a) begin
      s_slab_pitch_r <= PB'(sw0) * PB'(sw1);
      d_slab_pitch_r <= PB'(dw0) * PB'(dw1);
    end
    if (cmd.pitch_b) begin
      s_layer_pitch_r <= INDEX_BITS'(LB'(s_slab_pitch_r) * LB'(sw2));
      d_layer_pitch_r <= INDEX_BITS'(LB'(d_slab_pitch_r) * LB'(dw2));
    end
  end

  // walk position and bases
  logic [EB-1:0]         pos_x_r, pos_y_r, pos_z_r, pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [LPB-1:0]        layer_pos_r, layer_pos_nxt;
  logic [INDEX_BITS-1:0] s_row_r, s_slab_r, s_layer_r, s_row_nxt, s_slab_nxt, s_layer_nxt;
  logic [INDEX_BITS-1:0] d_row_r, d_slab_r, d_layer_r, d_row_nxt, d_slab_nxt, d_layer_nxt;
  logic [INDEX_BITS-1:0] s_row_adv, s_slab_adv, s_layer_adv;
  logic [INDEX_BITS-1:0] d_row_adv, d_slab_adv, d_layer_adv;

  assign s_row_adv   = s_row_r + INDEX_BITS'(sw0);
  assign d_row_adv   = d_row_r + INDEX_BITS'(dw0);
  assign s_slab_adv  = s_slab_r + INDEX_BITS'(s_slab_pitch_r);
  assign d_slab_adv  = d_slab_r + INDEX_BITS'(d_slab_pitch_r);
  assign s_layer_adv = s_layer_r + s_layer_pitch_r;
  assign d_layer_adv = d_layer_r + d_layer_pitch_r;

  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    layer_pos_nxt = layer_pos_r;
    s_row_nxt     = s_row_r;
    s_slab_nxt    = s_slab_r;
    s_layer_nxt   = s_layer_r;
    d_row_nxt     = d_row_r;
    d_slab_nxt    = d_slab_r;
    d_layer_nxt   = d_layer_r;
    if (cmd.step) begin
      if (!restart && (pos_x_r < rx)) begin
        pos_x_nxt = pos_x_r + EB'(1);
      end else if (!restart && (pos_y_r < ry)) begin
        pos_x_nxt = '0;
        pos_y_nxt = pos_y_r + EB'(1);
        s_row_nxt = s_row_adv;
        d_row_nxt = d_row_adv;
      end else if (!restart && (pos_z_r < rz)) begin
        pos_x_nxt  = '0;
        pos_y_nxt  = '0;
        pos_z_nxt  = pos_z_r + EB'(1);
        s_slab_nxt = s_slab_adv;
        s_row_nxt  = s_slab_adv;
        d_slab_nxt = d_slab_adv;
        d_row_nxt  = d_slab_adv;
      end else if (!restart && (layer_pos_r < layers_m1)) begin
        pos_x_nxt     = '0;
        pos_y_nxt     = '0;
        pos_z_nxt     = '0;
        layer_pos_nxt = layer_pos_r + LPB'(1);
        s_layer_nxt   = s_layer_adv;
        s_slab_nxt    = s_layer_adv;
        s_row_nxt     = s_layer_adv;
        d_layer_nxt   = d_layer_adv;
        d_slab_nxt    = d_layer_adv;
        d_row_nxt     = d_layer_adv;
      end else begin
        // restart, or wrap after the final element
        pos_x_nxt     = '0;
        pos_y_nxt     = '0;
        pos_z_nxt     = '0;
        layer_pos_nxt = '0;
        s_row_nxt     = src_first;
        s_slab_nxt    = src_first;
        s_layer_nxt   = src_first;
        d_row_nxt     = dst_first;
        d_slab_nxt    = dst_first;
        d_layer_nxt   = dst_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      layer_pos_r <= '0;
      s_row_r     <= '0;
      s_slab_r    <= '0;
      s_layer_r   <= '0;
      d_row_r     <= '0;
      d_slab_r    <= '0;
      d_layer_r   <= '0;
    end else begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
      layer_pos_r <= layer_pos_nxt;
      s_row_r     <= s_row_nxt;
      s_slab_r    <= s_slab_nxt;
      s_layer_r   <= s_layer_nxt;
      d_row_r     <= d_row_nxt;
      d_slab_r    <= d_slab_nxt;
      d_layer_r   <= d_layer_nxt;
    end
  end

  // output word, built from the updated position
  logic                  run_end_w;
  logic [INDEX_BITS-1:0] source_index_r, dest_index_r;
  logic [LPB-1:0]        layer_index_r;
  logic                  run_end_r, last_r;
  assign run_end_w = (pos_x_r >= rx);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      source_index_r <= s_row_r + INDEX_BITS'(pos_x_r);
      dest_index_r   <= d_row_r + INDEX_BITS'(pos_x_r);
      layer_index_r  <= layer_pos_r;
      run_end_r      <= run_end_w;
      last_r         <= run_end_w && (pos_y_r >= ry) && (pos_z_r >= rz) &&
                        (layer_pos_r >= layers_m1);
    end
  end

  assign source_index = source_index_r;
  assign dest_index   = dest_index_r;
  assign layer_index  = layer_index_r;
  assign run_end      = run_end_r;
  assign last         = last_r;

endmodule

[rtl/core/box_region_copy_address_walker_core.sv]
// the result word of an accepted request is registered in the emit state of the controller
// no new request word is taken until the step/emit pair of the controller is done
// slab and layer pitches are recomputed in the pitch a and pitch b states after reset and
// after each register write, with in ready low during that time
// reset (synchronous, rst_n low) clears the walk position and bases, and the registers
// to zero except layer count, which resets to one
module box_region_copy_address_walker_core #(
  parameter int DIMS        = brcw_pkg::DIMS_DEF,
  parameter int EXTENT_BITS = brcw_pkg::EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = brcw_pkg::INDEX_BITS_DEF,
  localparam int CFG_W      = (3 * EXTENT_BITS > INDEX_BITS) ? 3 * EXTENT_BITS : INDEX_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  brcw_in_if.sink                              in_if,
  brcw_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [brcw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data
);

  logic [3*EXTENT_BITS-1:0]               region, src_ext, dst_ext;
  logic [brcw_pkg::LAYER_COUNT_BITS-1:0]  layers;
  logic [INDEX_BITS-1:0]                  src_first, dst_first;
  brcw_pkg::cmd_t                         cmd;
  logic                                   in_ready, out_valid;

  brcw_cfg_regs #(
    .EXTENT_BITS (EXTENT_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .CFG_W       (CFG_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .region_r    (region),
    .src_ext_r   (src_ext),
    .dst_ext_r   (dst_ext),
    .layers_r    (layers),
    .src_first_r (src_first),
    .dst_first_r (dst_first)
  );

  brcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  brcw_datapath #(
    .DIMS        (DIMS),
    .EXTENT_BITS (EXTENT_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .restart      (in_if.restart),
    .region       (region),
    .src_ext      (src_ext),
    .dst_ext      (dst_ext),
    .layers       (layers),
    .src_first    (src_first),
    .dst_first    (dst_first),
    .source_index (out_if.source_index),
    .dest_index   (out_if.dest_index),
    .layer_index  (out_if.layer_index),
    .run_end      (out_if.run_end),
    .last         (out_if.last)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

`ifndef SYNTHESIS
  // one request word in flight at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while previous word still in flight");

  // every accepted request yields a valid result word
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> ##2 out_if.valid)
    else $error("result word missing after accepted request");

  // the final element always closes a run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.last) |-> out_if.run_end)
    else $error("last set without run_end");
`endif

endmodule
